FILE: src/lbrd_pkg.sv
// ----------------------------------------------------------------------------
// lbrd_pkg: shared types and constants
// Generator constants, request kinds and widths for the bounded random draw.
// ----------------------------------------------------------------------------
package lbrd_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned FRAC_W = 15;
  localparam int unsigned OUT_W  = 48;

  localparam logic [WORD_W-1:0] LCG_MUL       = 32'h5D58_8B65;
  localparam logic [WORD_W-1:0] LCG_INC       = 32'h0000_0001;
  localparam logic [WORD_W-1:0] SEED_INIT     = 32'h0000_0001;
  localparam logic [WORD_W-1:0] WORD_ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] ONE_RANGE     = 32'd1000;
  localparam logic [WORD_W-1:0] ONE_THRESHOLD = 32'd500;
  localparam logic [WORD_W-1:0] HUNDRED_RANGE = 32'd1009;
  localparam logic [WORD_W-1:0] MAG_ONE       = 32'd1;
  localparam logic [WORD_W-1:0] MAG_HUNDRED   = 32'd100;
  localparam logic [WORD_W-1:0] TEN           = 32'd10;

  // reciprocal of ten: (d * 205) >> 11 equals d / 10 for every d below 1029
  localparam logic [18:0]       TENTH_MUL     = 19'd205;

  // request kind carried on tuser
  typedef enum logic {
    FUNC_RAW     = 1'b0,
    FUNC_BOUNDED = 1'b1
  } func_t;

endpackage

FILE: src/lbrd_lcg.sv
// ----------------------------------------------------------------------------
// lbrd_lcg: generator seed register
// Holds the 32-bit seed and advances it by one multiply-add on step.
// ----------------------------------------------------------------------------
module lbrd_lcg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  output logic [lbrd_pkg::WORD_W-1:0] seed
);

  logic [lbrd_pkg::WORD_W-1:0] seed_next;

  assign seed_next = seed * lbrd_pkg::LCG_MUL + lbrd_pkg::LCG_INC;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= lbrd_pkg::SEED_INIT;
    end else if (step) begin
      seed <= seed_next;
    end
  end

endmodule

FILE: src/lbrd_div.sv
// ----------------------------------------------------------------------------
// lbrd_div: shared unsigned divider
// Restoring division, one quotient bit per cycle, done pulses after 32 steps.
// ----------------------------------------------------------------------------
module lbrd_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lbrd_pkg::WORD_W-1:0] dividend,
  input  logic [lbrd_pkg::WORD_W-1:0] divisor,
  output logic                        done,
  output logic [lbrd_pkg::WORD_W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(lbrd_pkg::WORD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(lbrd_pkg::WORD_W - 1);

  logic                        busy;
  logic [CNT_W-1:0]            cnt;
  logic [lbrd_pkg::WORD_W-1:0] rem;
  logic [lbrd_pkg::WORD_W-1:0] dvs;
  logic [lbrd_pkg::WORD_W:0]   shifted;
  logic [lbrd_pkg::WORD_W:0]   trial;

  assign shifted = {rem, quotient[lbrd_pkg::WORD_W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        // remainder stays below the divisor, so the shifted value fits 33 bits
        if (trial[lbrd_pkg::WORD_W]) begin
          rem <= shifted[lbrd_pkg::WORD_W-1:0];
        end else begin
          rem <= trial[lbrd_pkg::WORD_W-1:0];
        end
        quotient <= {quotient[lbrd_pkg::WORD_W-2:0], ~trial[lbrd_pkg::WORD_W]};
        cnt      <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: src/lcg_bounded_random_draw.sv
// Raw request: S_RAW takes the stepped seed, then S_FINISH loads the output.
// Zero-maximum bounded request goes straight to S_FINISH. Other bounded
//   requests run the partition divide, then a load and a divide per draw.
// Throughput: one request at a time; s_tready is high only while idle.
// Bounded-request rate is set by the single shared bit-serial divider.
// Reset: synchronous, active high; seed returns to 1, output register empties.
// ----------------------------------------------------------------------------
// lcg_bounded_random_draw: LCG draw with rejection-sampled bounded range
// Raw requests return the next generator word; bounded requests return a
// uniform value in [0, n] by rejection, shaped for the magic maxima 1 and 100.
// ----------------------------------------------------------------------------
module lcg_bounded_random_draw (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] max_value (signed)
  input  logic [0:0]  s_tuser,   // [0] func
  // result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // [31:0] value, [46:32] fraction, [47] zero
);

  localparam int unsigned W = lbrd_pkg::WORD_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RAW,
    S_PART,
    S_DRAW,
    S_DIVD,
    S_FINISH
  } state_t;

  // shaping applied after the draw
  typedef enum logic [1:0] {
    BND_PLAIN,
    BND_ONE,
    BND_HUNDRED
  } bnd_t;

  state_t         state;
  bnd_t           bnd;
  bnd_t           bnd_sel;
  logic [W-1:0]   n;
  logic [W-1:0]   n_sel;
  logic [W-1:0]   part;
  logic [W-1:0]   res;
  logic [W-1:0]   mag;
  logic           accept;
  logic           is_raw;
  logic [18:0]    tenth_prod;

  logic           lcg_step;
  logic [W-1:0]   seed;

  logic           div_start;
  logic [W-1:0]   div_a;
  logic [W-1:0]   div_b;
  logic           div_done;
  logic [W-1:0]   div_q;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign is_raw   = (lbrd_pkg::func_t'(s_tuser[0]) == lbrd_pkg::FUNC_RAW);

  // magnitude; -2^31 wraps to 2^31 read unsigned
  assign mag = s_tdata[W-1] ? (W'(0) - s_tdata) : s_tdata;

  // accepted draw for max 100 is at most 1009, so 11 bits cover it
  assign tenth_prod = {8'd0, div_q[10:0]} * lbrd_pkg::TENTH_MUL;

  always_comb begin
    if (mag == lbrd_pkg::MAG_ONE) begin
      bnd_sel = BND_ONE;
      n_sel   = lbrd_pkg::ONE_RANGE;
    end else if (mag == lbrd_pkg::MAG_HUNDRED) begin
      bnd_sel = BND_HUNDRED;
      n_sel   = lbrd_pkg::HUNDRED_RANGE;
    end else begin
      bnd_sel = BND_PLAIN;
      n_sel   = mag;
    end
  end

  // generator advances on a raw request, after the partition, and on rejection
  always_comb begin
    lcg_step = 1'b0;
    case (state)
      S_IDLE:  lcg_step = accept && is_raw;
      S_PART:  lcg_step = div_done;
      S_DIVD:  lcg_step = div_done && (div_q > n);
      default: lcg_step = 1'b0;
    endcase
  end

  lbrd_lcg u_lcg (
    .clk  (clk),
    .rst  (rst),
    .step (lcg_step),
    .seed (seed)
  );

  lbrd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_start <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      div_start <= 1'b0;
      // in S_FINISH the output register is reloaded below instead
      if (m_tvalid && m_tready && (state != S_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (is_raw) begin
              state <= S_RAW;
            end else if (mag == '0) begin
              // zero maximum: no step, value 0
              res   <= '0;
              state <= S_FINISH;
            end else begin
              bnd       <= bnd_sel;
              n         <= n_sel;
              div_a     <= lbrd_pkg::WORD_ALL_ONES;
              div_b     <= n_sel + 1'b1;
              div_start <= 1'b1;
              state     <= S_PART;
            end
          end
        end
        S_RAW: begin
          res   <= seed;
          state <= S_FINISH;
        end
        S_PART: begin
          if (div_done) begin
            part  <= (div_q == '0) ? W'(1) : div_q;
            state <= S_DRAW;
          end
        end
        S_DRAW: begin
          div_a     <= seed;
          div_b     <= part;
          div_start <= 1'b1;
          state     <= S_DIVD;
        end
        S_DIVD: begin
          if (div_done) begin
            if (div_q > n) begin
              state <= S_DRAW;   // rejected, seed already stepped
            end else begin
              case (bnd)
                BND_ONE: begin
                  res   <= {{(W-1){1'b0}}, (div_q > lbrd_pkg::ONE_THRESHOLD)};
                  state <= S_FINISH;
                end
                BND_HUNDRED: begin
                  // divide by ten through the reciprocal product
                  res   <= {{(W-8){1'b0}}, tenth_prod[18:11]};
                  state <= S_FINISH;
                end
                default: begin
                  res   <= div_q;
                  state <= S_FINISH;
                end
              endcase
            end
          end
        end
        S_FINISH: begin
          // wait for the output register to drain
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, seed[lbrd_pkg::FRAC_W-1:0], res};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/lbrd_chk.sv
// ----------------------------------------------------------------------------
// lbrd_chk: port-level checks
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
module lbrd_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic [0:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // one request at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  // a new result never appears while the block could take a request
  a_new_result: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result without a request in flight");

  // pad bit stays zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[47])
    else $error("pad bit set");

endmodule

bind lcg_bounded_random_draw lbrd_chk u_lbrd_chk (.*);

FILE: dv/lcg_bounded_random_draw_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_bounded_random_draw_test: request/result check of the bounded draw block
// Sends raw and bounded draw requests and tracks the generator seed alongside
// the block. Each returned word and fraction is compared with the prediction.
// The random part runs under four flow-control phases.
// ----------------------------------------------------------------------------
module lcg_bounded_random_draw_test;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned ITEMS_PER_PHASE = 300;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [lbrd_pkg::FRAC_W-1:0] fraction;
    logic [lbrd_pkg::WORD_W-1:0] value;
  } draw_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;

  lcg_bounded_random_draw i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // predictor state: a private copy of the generator seed
  logic [lbrd_pkg::WORD_W-1:0] gen_seed;
  draw_result_t                pending_draws[$];

  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned raw_sent;
  int unsigned bounded_sent;
  int unsigned zero_max_sent;
  int unsigned magic_sent;
  int unsigned results_seen;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---- predictor --------------------------------------------------------

  function automatic logic [lbrd_pkg::WORD_W-1:0] lcg_advance();
    gen_seed = gen_seed * lbrd_pkg::LCG_MUL + lbrd_pkg::LCG_INC;
    return gen_seed;
  endfunction

  // uniform value in [0, n] by rejection on word / partition
  function automatic logic [lbrd_pkg::WORD_W-1:0] draw_upto_range(
    logic [lbrd_pkg::WORD_W-1:0] n
  );
    logic [lbrd_pkg::WORD_W-1:0] span;
    logic [lbrd_pkg::WORD_W-1:0] part;
    logic [lbrd_pkg::WORD_W-1:0] d;
    span = n + 32'd1;
    part = (span == '0) ? 32'd1 : lbrd_pkg::WORD_ALL_ONES / span;
    if (part == '0) begin
      part = 32'd1;
    end
    do begin
      d = lcg_advance() / part;
    end while (d > n);
    return d;
  endfunction

  function automatic draw_result_t predict_request(
    lbrd_pkg::func_t f,
    logic [lbrd_pkg::WORD_W-1:0] max_raw
  );
    draw_result_t                r;
    logic [lbrd_pkg::WORD_W-1:0] mag;
    if (f == lbrd_pkg::FUNC_RAW) begin
      r.value = lcg_advance();
    end else begin
      // magnitude wraps for the most negative maximum and reads as 2^31
      mag = max_raw[lbrd_pkg::WORD_W-1] ? (32'd0 - max_raw) : max_raw;
      if (mag == '0) begin
        r.value = '0;
      end else if (mag == lbrd_pkg::MAG_ONE) begin
        r.value = (draw_upto_range(lbrd_pkg::ONE_RANGE) > lbrd_pkg::ONE_THRESHOLD) ?
                  32'd1 : 32'd0;
      end else if (mag == lbrd_pkg::MAG_HUNDRED) begin
        r.value = draw_upto_range(lbrd_pkg::HUNDRED_RANGE) / lbrd_pkg::TEN;
      end else begin
        r.value = draw_upto_range(mag);
      end
    end
    r.fraction = gen_seed[lbrd_pkg::FRAC_W-1:0];
    return r;
  endfunction

  // ---- request driver ---------------------------------------------------

  task automatic send_request(lbrd_pkg::func_t f, logic [31:0] max_raw);
    logic [lbrd_pkg::WORD_W-1:0] mag;
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= max_raw;
    do begin
      @(posedge clk);
    end while (!s_tready);
    pending_draws.push_back(predict_request(f, max_raw));
    mag = max_raw[31] ? (32'd0 - max_raw) : max_raw;
    if (f == lbrd_pkg::FUNC_RAW) begin
      raw_sent++;
    end else begin
      bounded_sent++;
      if (mag == '0) zero_max_sent++;
      if (mag == lbrd_pkg::MAG_ONE || mag == lbrd_pkg::MAG_HUNDRED) magic_sent++;
    end
  endtask

  // ---- result side ------------------------------------------------------

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    draw_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_draws.size() == 0) begin
        $error("result with no request outstanding: %h", m_tdata);
        fail_count++;
      end else begin
        want = pending_draws.pop_front();
        if (m_tdata[31:0] !== want.value) begin
          $error("value: expected %h, got %h", want.value, m_tdata[31:0]);
          fail_count++;
        end
        if (m_tdata[46:32] !== want.fraction) begin
          $error("fraction: expected %h, got %h", want.fraction, m_tdata[46:32]);
          fail_count++;
        end
        if (m_tdata[47] !== 1'b0) begin
          $error("pad: expected 0, got %b", m_tdata[47]);
          fail_count++;
        end
      end
    end
  end

  // ---- tests ------------------------------------------------------------

  // raw draws straight from the reset seed; max_value must be ignored
  task automatic test_raw_sequence();
    send_request(lbrd_pkg::FUNC_RAW, 32'd0);
    send_request(lbrd_pkg::FUNC_RAW, 32'h8000_0000);
    send_request(lbrd_pkg::FUNC_RAW, 32'hFFFF_FFFF);
  endtask

  // zero maximum: result 0, seed untouched, fraction shows the current seed
  task automatic test_zero_max();
    send_request(lbrd_pkg::FUNC_BOUNDED, 32'd0);
    send_request(lbrd_pkg::FUNC_RAW, 32'h0000_1234);
    send_request(lbrd_pkg::FUNC_BOUNDED, 32'd0);
  endtask

  // maxima 1 and 100 take the shaped paths, with either sign
  task automatic test_magic_maxima();
    send_request(lbrd_pkg::FUNC_BOUNDED, 32'd1);
    send_request(lbrd_pkg::FUNC_BOUNDED, 32'hFFFF_FFFF);
    send_request(lbrd_pkg::FUNC_BOUNDED, 32'd100);
    send_request(lbrd_pkg::FUNC_BOUNDED, 32'hFFFF_FF9C);
  endtask

  task automatic test_extreme_maxima();
    send_request(lbrd_pkg::FUNC_BOUNDED, 32'h7FFF_FFFF);
    send_request(lbrd_pkg::FUNC_BOUNDED, 32'h8000_0000);  // most negative, magnitude 2^31
    send_request(lbrd_pkg::FUNC_BOUNDED, 32'h8000_0001);
    send_request(lbrd_pkg::FUNC_BOUNDED, 32'd2);
    send_request(lbrd_pkg::FUNC_BOUNDED, 32'hFFFF_FFFE);
    send_request(lbrd_pkg::FUNC_BOUNDED, 32'h4000_0000);
    send_request(lbrd_pkg::FUNC_BOUNDED, 32'd99);
    send_request(lbrd_pkg::FUNC_BOUNDED, 32'd101);
    send_request(lbrd_pkg::FUNC_BOUNDED, 32'd1000);
    send_request(lbrd_pkg::FUNC_BOUNDED, 32'd1009);
  endtask

  function automatic logic [31:0] random_max();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'd0;
      1: v = lbrd_pkg::MAG_ONE;
      2: v = lbrd_pkg::MAG_HUNDRED;
      3: v = $urandom_range(2, 4095);
      4: v = 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: v = $urandom();
    endcase
    if ($urandom_range(0, 1) == 1) begin
      v = 32'd0 - v;
    end
    return v;
  endfunction

  task automatic test_random_mix(int unsigned idle_pct, int unsigned stall_pct);
    lbrd_pkg::func_t f;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    repeat (ITEMS_PER_PHASE) begin
      f = ($urandom_range(0, 99) < 30) ? lbrd_pkg::FUNC_RAW : lbrd_pkg::FUNC_BOUNDED;
      send_request(f, (f == lbrd_pkg::FUNC_RAW) ? $urandom() : random_max());
    end
  endtask

  // ---- run control ------------------------------------------------------

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("timeout after %0d cycles, %0d results outstanding", cycle_count,
           pending_draws.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = lbrd_pkg::FUNC_RAW;
    gen_seed       = lbrd_pkg::SEED_INIT;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    fail_count     = 0;
    raw_sent       = 0;
    bounded_sent   = 0;
    zero_max_sent  = 0;
    magic_sent     = 0;
    results_seen   = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_raw_sequence();
    test_zero_max();
    test_magic_maxima();
    test_extreme_maxima();
    test_random_mix(0, 0);
    test_random_mix(59, 0);
    test_random_mix(0, 59);
    test_random_mix(19, 19);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_draws.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d raw and %0d bounded requests (%0d zero max, %0d magic max).",
             raw_sent, bounded_sent, zero_max_sent, magic_sent);
    $display("Checked %0d results over four flow-control phases in %0d cycles.",
             results_seen, cycle_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
